// ===== sv/direct_form_iir_filter_assert.svh =====
// ----------------------------------------------------------------------------
// direct_form_iir_filter_assert.svh
// assertion macros used by the filter top level
// ----------------------------------------------------------------------------
`ifndef DIRECT_FORM_IIR_FILTER_ASSERT_SVH
`define DIRECT_FORM_IIR_FILTER_ASSERT_SVH

// same-cycle implication
`define DFI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dfi_pkg.sv =====
// ----------------------------------------------------------------------------
// dfi_pkg
// types and constants of the direct form iir filter
// ----------------------------------------------------------------------------
package dfi_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int DEF_ORDER      = 3;
   localparam int MAX_ORDER      = 3;
   localparam int NUM_REGS       = 8;
   localparam int REG_IDX_W      = 3;
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int ACC_W          = PROD_W + 3;
   localparam int CNT_W          = $clog2(ACC_W + 1);
   localparam int SEL_W          = $clog2(2 * MAX_ORDER + 2);

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);

   localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_B3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_A0 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_sample;
      logic                       start_of_signal;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       saturated;
      logic                       divisor_zero_error;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic             load;
      logic             mul_en;
      logic             acc_en;
      logic [SEL_W-1:0] sel;
      logic             div_init;
      logic             div_en;
      logic             write;
   } cmd_type;

   typedef struct packed {
      logic a0_zero;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/dfi_datapath.sv =====
// ----------------------------------------------------------------------------
// dfi_datapath
// coefficient registers, histories, shared multiplier, accumulator,
// serial divider and output register
// ----------------------------------------------------------------------------
module dfi_datapath #(
   parameter int ORDER = dfi_pkg::DEF_ORDER
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dfi_pkg::req_type                     req_data,
   input  logic                                 csr_we,
   input  logic [dfi_pkg::REG_IDX_W-1:0]        csr_index,
   input  logic [dfi_pkg::COEF_W-1:0]           csr_wdata,
   input  dfi_pkg::cmd_type                     cmd,
   output dfi_pkg::sts_type                     sts,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output dfi_pkg::rsp_type                     rsp_data
);
   import dfi_pkg::*;

   localparam logic [ACC_W-1:0] MAX_POS = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic [ACC_W-1:0] MAX_NEG = ACC_W'(1 << (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W-1:0] SAT_HI = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [SAMPLE_W-1:0] SAT_LO = SAMPLE_W'(1 << (SAMPLE_W - 1));

   logic signed [COEF_W-1:0]   coef_ff [NUM_REGS];
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] xh_ff [ORDER];
   logic signed [SAMPLE_W-1:0] yh_ff [ORDER];
   logic                       err_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       neg_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]           quo_ff;
   logic [COEF_W-1:0]          rem_ff;
   logic [COEF_W-1:0]          den_ff;
   logic                       qneg_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   logic signed [COEF_W-1:0]   op_c;
   logic signed [SAMPLE_W-1:0] op_x;
   logic                       op_neg;
   logic                       a0_zero;
   logic [COEF_W:0]            rem_sh;
   logic [COEF_W:0]            den_ext;
   logic                       q_bit;
   logic [ACC_W-1:0]           acc_mag;
   logic [ACC_W-1:0]           quo_neg;
   logic signed [SAMPLE_W-1:0] q_sat;
   logic                       sat;

   assign a0_zero      = (coef_ff[REG_A0] == '0);
   assign sts.a0_zero  = a0_zero;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // operand select for the shared multiplier
   always_comb begin
      op_c   = coef_ff[REG_B0];
      op_x   = x_ff;
      op_neg = 1'b0;
      for (int k = 0; k < ORDER; k++) begin
         if (cmd.sel == SEL_W'(2 * k + 1)) begin
            op_c   = coef_ff[REG_IDX_W'(int'(REG_B1) + k)];
            op_x   = xh_ff[k];
            op_neg = 1'b0;
         end
         if (cmd.sel == SEL_W'(2 * k + 2)) begin
            op_c   = coef_ff[REG_IDX_W'(int'(REG_A1) + k)];
            op_x   = yh_ff[k];
            op_neg = 1'b1;
         end
      end
   end

   // restoring divider step and result saturation
   always_comb begin
      acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      rem_sh  = {rem_ff, quo_ff[ACC_W-1]};
      den_ext = {1'b0, den_ff};
      q_bit   = (rem_sh >= den_ext);
      quo_neg = ACC_W'(0) - quo_ff;
      if (qneg_ff) begin
         sat   = (quo_ff > MAX_NEG);
         q_sat = sat ? SAT_LO : quo_neg[SAMPLE_W-1:0];
      end else begin
         sat   = (quo_ff > MAX_POS);
         q_sat = sat ? SAT_HI : quo_ff[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (REG_IDX_W'(i) == REG_B0 || REG_IDX_W'(i) == REG_A0) begin
               coef_ff[REG_IDX_W'(i)] <= COEF_ONE;
            end else begin
               coef_ff[REG_IDX_W'(i)] <= '0;
            end
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            xh_ff[k] <= '0;
            yh_ff[k] <= '0;
         end
      end else if (cmd.load && req_data.start_of_signal && !a0_zero) begin
         for (int k = 0; k < ORDER; k++) begin
            xh_ff[k] <= '0;
            yh_ff[k] <= '0;
         end
      end else if (cmd.write && !err_ff) begin
         for (int k = ORDER - 1; k > 0; k--) begin
            xh_ff[k] <= xh_ff[k-1];
            yh_ff[k] <= yh_ff[k-1];
         end
         xh_ff[0] <= x_ff;
         yh_ff[0] <= q_sat;
      end
   end

   // multiply, accumulate, divide
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= req_data.in_sample;
         err_ff <= a0_zero;
         acc_ff <= '0;
      end
      if (cmd.mul_en) begin
         prod_ff <= op_c * op_x;
         neg_ff  <= op_neg;
      end
      if (cmd.acc_en) begin
         acc_ff <= neg_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.div_init) begin
         quo_ff  <= acc_mag;
         rem_ff  <= '0;
         den_ff  <= coef_ff[REG_A0][COEF_W-1] ? COEF_W'(-coef_ff[REG_A0])
                                              : COEF_W'(coef_ff[REG_A0]);
         qneg_ff <= acc_ff[ACC_W-1] ^ coef_ff[REG_A0][COEF_W-1];
      end else if (cmd.div_en) begin
         rem_ff <= q_bit ? COEF_W'(rem_sh - den_ext) : rem_sh[COEF_W-1:0];
         quo_ff <= {quo_ff[ACC_W-2:0], q_bit};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         if (err_ff) begin
            rsp_ff.out_sample         <= '0;
            rsp_ff.saturated          <= 1'b0;
            rsp_ff.divisor_zero_error <= 1'b1;
         end else begin
            rsp_ff.out_sample         <= q_sat;
            rsp_ff.saturated          <= sat;
            rsp_ff.divisor_zero_error <= 1'b0;
         end
      end
   end

endmodule

// ===== sv/dfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfi_ctrl
// sequencer for the multiply-accumulate, divide and write-back phases
// ----------------------------------------------------------------------------
module dfi_ctrl #(
   parameter int ORDER = dfi_pkg::DEF_ORDER
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfi_pkg::sts_type sts,
   output dfi_pkg::cmd_type cmd
);
   import dfi_pkg::*;

   localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(2 * ORDER + 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sel   = cnt_ff[SEL_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = sts.a0_zero ? ST_WRITE : ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mul_en = (cnt_ff < MAC_LAST);
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == MAC_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_init = (cnt_ff == '0);
            cmd.div_en   = (cnt_ff != '0);
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/direct_form_iir_filter.sv =====
// ----------------------------------------------------------------------------
// direct_form_iir_filter - third-order direct form i iir filter
// accept, multiply-accumulate, 35-step divide, write; a zero a0 skips to write
// shared multiplier; a new sample is taken only after the last result is written
// reset restores b0 = a0 = 1.0, other coefficients and both histories to zero
// ----------------------------------------------------------------------------
`include "direct_form_iir_filter_assert.svh"

module direct_form_iir_filter #(
   parameter int ORDER = dfi_pkg::DEF_ORDER
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dfi_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dfi_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [dfi_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [dfi_pkg::COEF_W-1:0]    csr_wdata
);
   import dfi_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dfi_ctrl #(
      .ORDER (ORDER)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dfi_datapath #(
      .ORDER (ORDER)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `DFI_ASSERT_NOW(a_write_needs_room, clock, reset, cmd.write, sts.out_free,
      "result written while output register still full")
   `DFI_ASSERT_NEXT(a_write_shows_item, clock, reset, cmd.write, rsp_valid,
      "written result not presented")
   `DFI_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready && !sts.a0_zero, !req_ready,
      "new item taken while a filter item is in progress")
   `DFI_ASSERT_NOW(a_one_phase, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.mul_en || cmd.acc_en, cmd.div_init || cmd.div_en, cmd.write}),
      "datapath commands from two phases at once")

endmodule

// ===== tb/direct_form_iir_filter_tb.sv =====
// ----------------------------------------------------------------------------
// direct_form_iir_filter_tb
// directed table then random coefficient phases, every item checked
// against its row or in-bench model, random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module direct_form_iir_filter_tb;
   import dfi_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 4;
   localparam int NUM_PHASES      = 20;
   localparam int PHASE_ITEMS     = 110;
   localparam int ZERO_DIV_ITEMS  = 20;
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int RUN_LIMIT_NS    = 15_000_000;
   localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
   localparam int NUM_ROWS        = 40;

   typedef enum {ROW_WRITE, ROW_ITEM} row_kind_type;
   typedef enum {PH_FIR, PH_DAMPED, PH_WILD, PH_EXTREME, PH_ZERO_DIV} phase_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [REG_IDX_W-1:0]  idx;
      int                    value;
      bit                    start;
      bit                    typed;
      int                    exp_out;
      bit                    exp_sat;
      bit                    exp_err;
   } row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [REG_IDX_W-1:0]  csr_index = '0;
   logic [COEF_W-1:0]     csr_wdata = '0;

   logic signed [COEF_W-1:0] coef_model [NUM_REGS] =
      '{COEF_ONE, '0, '0, '0, COEF_ONE, '0, '0, '0};
   logic signed [SAMPLE_W-1:0] x_hist [MAX_ORDER] = '{default: '0};
   logic signed [SAMPLE_W-1:0] y_hist [MAX_ORDER] = '{default: '0};

   rsp_type expected_out [$];
   int      mismatches      = 0;
   int      results_checked = 0;
   int      clipped_seen    = 0;
   int      div_zero_seen   = 0;
   int      stall_left      = 0;
   bit      hold_off_done   = 1'b0;
   bit      rx_steady       = 1'b0;
   bit      tx_steady       = 1'b0;

   row_type directed_rows [NUM_ROWS] = '{
      '{ROW_ITEM,  REG_B0,      0, 1, 1,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,  32767, 0, 1,  32767, 0, 0},
      '{ROW_ITEM,  REG_B0, -32768, 0, 1, -32768, 0, 0},
      '{ROW_ITEM,  REG_B0,      1, 1, 1,      1, 0, 0},
      '{ROW_WRITE, REG_A0,      0, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,   1234, 1, 1,      0, 0, 1},
      '{ROW_ITEM,  REG_B0, -32768, 0, 1,      0, 0, 1},
      '{ROW_WRITE, REG_A0,      1, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,      1, 1, 1,  16384, 0, 0},
      '{ROW_ITEM,  REG_B0,      2, 0, 1,  32767, 1, 0},
      '{ROW_ITEM,  REG_B0,     -3, 0, 1, -32768, 1, 0},
      '{ROW_ITEM,  REG_B0,  32767, 0, 1,  32767, 1, 0},
      '{ROW_ITEM,  REG_B0, -32768, 0, 1, -32768, 1, 0},
      '{ROW_WRITE, REG_B0, -32768, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A0, -32768, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0, -32768, 0, 1, -32768, 0, 0},
      '{ROW_ITEM,  REG_B0,  32767, 0, 1,  32767, 0, 0},
      '{ROW_ITEM,  REG_B0,     -1, 0, 1,     -1, 0, 0},
      '{ROW_WRITE, REG_B0,      1, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A0,     -3, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,      7, 0, 1,     -2, 0, 0},
      '{ROW_ITEM,  REG_B0,     -7, 0, 1,      2, 0, 0},
      '{ROW_WRITE, REG_B0,  32767, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_B1,  32767, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_B2, -32768, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_B3,  12345, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A0,  16384, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A1, -32768, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A2,  32767, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A3,     -1, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,   1000, 1, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,  -2000, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,  32767, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0, -32768, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,    555, 1, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,      0, 0, 0,      0, 0, 0},
      '{ROW_WRITE, REG_A0,      0, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,   4321, 1, 1,      0, 0, 1},
      '{ROW_WRITE, REG_A0,  16384, 0, 0,      0, 0, 0},
      '{ROW_ITEM,  REG_B0,      0, 0, 0,      0, 0, 0}
   };

   direct_form_iir_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic rsp_type iir_predict(input req_type item);
      rsp_type outcome;
      longint  acc;
      longint  quo;
      outcome = '0;
      if (coef_model[REG_A0] == 0) begin
         outcome.divisor_zero_error = 1'b1;
         return outcome;
      end
      if (item.start_of_signal) begin
         x_hist = '{default: '0};
         y_hist = '{default: '0};
      end
      acc = longint'(coef_model[REG_B0]) * longint'(item.in_sample);
      for (int k = 0; k < MAX_ORDER; k++) begin
         acc += longint'(coef_model[REG_B1 + k]) * longint'(x_hist[k]);
         acc -= longint'(coef_model[REG_A1 + k]) * longint'(y_hist[k]);
      end
      quo = acc / longint'(coef_model[REG_A0]);
      if (quo > SAMPLE_MAX) begin
         quo = SAMPLE_MAX;
         outcome.saturated = 1'b1;
      end else if (quo < SAMPLE_MIN) begin
         quo = SAMPLE_MIN;
         outcome.saturated = 1'b1;
      end
      for (int k = MAX_ORDER - 1; k > 0; k--) begin
         x_hist[k] = x_hist[k-1];
         y_hist[k] = y_hist[k-1];
      end
      x_hist[0] = item.in_sample;
      y_hist[0] = SAMPLE_W'(quo);
      outcome.out_sample = SAMPLE_W'(quo);
      return outcome;
   endfunction

   function automatic int signed_range(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(input phase_kind_type kind, input int r);
      int v;
      case (kind)
         PH_FIR: begin
            if (r == REG_A0)
               v = 16384;
            else if (r > REG_A0)
               v = 0;
            else
               v = signed_range(-8192, 8192);
         end
         PH_DAMPED: begin
            if (r == REG_A0)
               v = 16384;
            else if (r > REG_A0)
               v = signed_range(-4096, 4096);
            else
               v = signed_range(-8192, 8192);
         end
         PH_EXTREME: begin
            case ($urandom_range(0, 5))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               3: v = 1;
               4: v = -1;
               default: v = 16384;
            endcase
            if (r == REG_A0 && v == 0)
               v = -32768;
         end
         PH_ZERO_DIV: begin
            v = (r == REG_A0) ? 0 : int'($urandom_range(0, 65535));
         end
         default: begin
            v = $urandom_range(0, 65535);
         end
      endcase
      return COEF_W'(v);
   endfunction

   function automatic req_type random_sample(input phase_kind_type kind);
      req_type item;
      int      r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0: item.in_sample = SAMPLE_W'(-32768);
            1: item.in_sample = SAMPLE_W'(32767);
            2: item.in_sample = '0;
            default: item.in_sample = '1;
         endcase
      end else if (r < 50 && kind != PH_WILD) begin
         item.in_sample = SAMPLE_W'(signed_range(-2000, 2000));
      end else begin
         item.in_sample = SAMPLE_W'($urandom_range(0, 65535));
      end
      item.start_of_signal = ($urandom_range(0, 99) < 3);
      return item;
   endfunction

   task automatic send_sample(input req_type item);
      int gap;
      gap = tx_steady ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // coefficients change only with the filter empty
   task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      coef_model[idx] = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $display("%0t: unexpected item out_sample %0d saturated %0b error %0b",
                        $time, rsp_data.out_sample, rsp_data.saturated,
                        rsp_data.divisor_zero_error);
               mismatches++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_data.out_sample !== want.out_sample) begin
                  $display("%0t: out_sample expected %0d got %0d",
                           $time, want.out_sample, rsp_data.out_sample);
                  mismatches++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b got %0b",
                           $time, want.saturated, rsp_data.saturated);
                  mismatches++;
               end
               if (rsp_data.divisor_zero_error !== want.divisor_zero_error) begin
                  $display("%0t: divisor_zero_error expected %0b got %0b",
                           $time, want.divisor_zero_error, rsp_data.divisor_zero_error);
                  mismatches++;
               end
               clipped_seen  += want.saturated;
               div_zero_seen += want.divisor_zero_error;
            end
            results_checked++;
         end
         // long hold-off so the filter backs up into the input
         if (!hold_off_done && results_checked >= HOLD_OFF_AT) begin
            stall_left    = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end
         if ($urandom_range(0, 149) == 0)
            rx_steady = !rx_steady;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 15)
               stall_left = gap_len();
         end
      end
   end

   initial begin
      req_type        item;
      rsp_type        outcome;
      phase_kind_type kind;
      int             n_items;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_coef(directed_rows[i].idx, COEF_W'(directed_rows[i].value));
         end else begin
            item.in_sample       = SAMPLE_W'(directed_rows[i].value);
            item.start_of_signal = directed_rows[i].start;
            send_sample(item);
            outcome = iir_predict(item);
            if (directed_rows[i].typed) begin
               outcome.out_sample         = SAMPLE_W'(directed_rows[i].exp_out);
               outcome.saturated          = directed_rows[i].exp_sat;
               outcome.divisor_zero_error = directed_rows[i].exp_err;
            end
            expected_out.push_back(outcome);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         kind = phase_kind_type'(p % 5);
         for (int r = 0; r < NUM_REGS; r++)
            write_coef(REG_IDX_W'(r), pick_coef(kind, r));
         tx_steady = ($urandom_range(0, 3) == 0);
         n_items   = (kind == PH_ZERO_DIV) ? ZERO_DIV_ITEMS : PHASE_ITEMS;
         repeat (n_items) begin
            item = random_sample(kind);
            send_sample(item);
            expected_out.push_back(iir_predict(item));
         end
      end

      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered the directed table and %0d random coefficient phases", NUM_PHASES);
      $display("%0d output samples checked, %0d clipped, %0d with zero divisor",
               results_checked, clipped_seen, div_zero_seen);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dfi_pkg.sv
sv/dfi_datapath.sv
sv/dfi_ctrl.sv
sv/direct_form_iir_filter.sv
tb/direct_form_iir_filter_tb.sv
